// File: hw/rtl/u1pa_pkg.sv
// Shared types and constants for the U(1) plaquette average block.
package u1pa_pkg;

  localparam int SUM_W = 48;   // accumulator width, wraps modulo 2^48
  localparam int AVG_W = 16;   // Q1.15 average width
  localparam int R_W   = 31;   // Q30 values below 2.0
  localparam int MAG_W = 15;   // Q15 cosine magnitude
  localparam int CFG_W = 25;   // lattice_sites register width
  localparam int NUM_CELLS = 5;

  localparam logic [R_W-1:0]   Q30_ONE     = 31'h4000_0000;
  localparam logic [MAG_W-1:0] COS_MAX     = 15'd32767;
  localparam logic [AVG_W-1:0] AVG_MAX     = 16'd32767;
  localparam logic [CFG_W-1:0] SITES_RESET = 25'd4096;

  // cos(pi*x/2) Taylor coefficients in Q30, constant term first
  localparam logic [R_W-1:0] COEF [0:5] = '{
    31'd1073741824, 31'd1324675879, 31'd272375560,
    31'd22401992, 31'd987048, 31'd27060
  };

  // data handed from one Horner cell to the next
  typedef struct packed {
    logic           vld;
    logic           neg;
    logic           tp;
    logic           last;
    logic [R_W-1:0] u;
    logic [R_W-1:0] r;
  } u1pa_bus_t;

  // divider status seen by the top level
  typedef struct packed {
    logic busy;
    logic res_valid;
  } u1pa_div_stat_t;

endpackage

// File: hw/rtl/u1pa_if.sv
// Valid/ready channel interfaces for plaquettes in and averages out.
interface u1pa_in_if #(
  parameter int PHASE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [PHASE_BITS-1:0] phase_first_here;
  logic [PHASE_BITS-1:0] phase_second_up_first;
  logic [PHASE_BITS-1:0] phase_first_up_second;
  logic [PHASE_BITS-1:0] phase_second_here;
  logic                  is_time_plane;
  logic                  last_item;

  modport source (
    output valid, phase_first_here, phase_second_up_first, phase_first_up_second,
    output phase_second_here, is_time_plane, last_item,
    input  ready
  );
  modport sink (
    input  valid, phase_first_here, phase_second_up_first, phase_first_up_second,
    input  phase_second_here, is_time_plane, last_item,
    output ready
  );
endinterface

interface u1pa_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] space_average;
  logic signed [15:0] time_average;

  modport source (
    output valid, space_average, time_average,
    input  ready
  );
  modport sink (
    input  valid, space_average, time_average,
    output ready
  );
endinterface

// File: hw/rtl/u1_plaquette_average.sv
// Top level of the U(1) plaquette average block.
//
// Usage:
//   in_ch  : one plaquette per transaction (four link phases, a time-plane
//            flag, a last marker); accepted when valid and ready are high.
//   out_ch : one transaction per sweep, carrying the space and time averages
//            of all plaquettes up to and including the one marked last.
//   cfg_*  : lattice_sites, written whenever cfg_write_en is high; write it
//            only while the block is idle.
// Datapath: angle fold, squaring stage, then a chain of five Horner cells
// that each take one step of the cosine polynomial and pass it on; one
// plaquette enters per cycle unless the input is held off. The cosine
// reaches the accumulators through the fold, squaring and cell registers.
// Sweep end: a last plaquette holds off the input until both averages have moved into the
// output register. It passes the chain, a register that hands the sums to the divider, the
// shared restoring divider (one average after the other) and the output register. The next
// sweep may start once the result is in the output register, while it still waits there.
// Reset: sums cleared, lattice_sites back to 4096, channels empty.
// A stalled receiver holds the result; a second last plaquette then waits.
module u1_plaquette_average import u1pa_pkg::*; #(
  parameter int PHASE_BITS      = 16,
  parameter int SITE_COUNT_BITS = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_write_en,
  input  logic [CFG_W-1:0] cfg_write_data,
  u1pa_in_if.sink          in_ch,
  u1pa_out_if.source       out_ch
);

  localparam int DW = SITE_COUNT_BITS + 2;  // 3 * sites
  localparam int SW = (SITE_COUNT_BITS + 1 > CFG_W) ? SITE_COUNT_BITS + 1 : CFG_W;
  localparam logic [SW-1:0] SITE_CAP = SW'(1) << SITE_COUNT_BITS;

  // configuration
  logic [CFG_W-1:0] sites_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sites_r <= SITES_RESET;
    end else if (cfg_write_en) begin
      sites_r <= cfg_write_data;
    end
  end

  // input handshake: held off from a last plaquette until its result moves out
  logic lock_r, lock_nxt;
  logic in_fire;
  logic res_take;

  assign in_ch.ready = !lock_r;
  assign in_fire     = in_ch.valid && !lock_r;

  // fold the plaquette angle into the first quadrant
  logic [PHASE_BITS-1:0] ang;
  logic [1:0]            quad;
  logic [29:0]           frac;
  logic [R_W-1:0]        x_nxt;

  assign ang  = in_ch.phase_first_here + in_ch.phase_second_up_first
              - in_ch.phase_first_up_second - in_ch.phase_second_here;
  assign quad = ang[PHASE_BITS-1 -: 2];
  assign frac = 30'({ang, {(32 - PHASE_BITS){1'b0}}});
  assign x_nxt = quad[0] ? (Q30_ONE - R_W'(frac)) : R_W'(frac);

  logic           a_vld_r;
  logic           a_neg_r;
  logic           a_tp_r;
  logic           a_last_r;
  logic [R_W-1:0] a_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_fire;
    end
    a_neg_r  <= quad[1] ^ quad[0];
    a_tp_r   <= in_ch.is_time_plane;
    a_last_r <= in_ch.last_item;
    a_x_r    <= x_nxt;
  end

  // squaring stage: u = x^2 in Q30, seeds the chain with the top coefficient
  logic [2*R_W-1:0] sq;
  u1pa_bus_t        bus [0:NUM_CELLS];
  u1pa_bus_t        sq_r;

  assign sq = a_x_r * a_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r.vld <= 1'b0;
    end else begin
      sq_r.vld <= a_vld_r;
    end
    sq_r.neg  <= a_neg_r;
    sq_r.tp   <= a_tp_r;
    sq_r.last <= a_last_r;
    sq_r.u    <= sq[60:30];
    sq_r.r    <= COEF[5];
  end

  assign bus[0] = sq_r;

  // Horner chain, highest coefficient first; every cell clamps at zero
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    u1pa_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .coef    (COEF[NUM_CELLS-1-k]),
      .bus_in  (bus[k]),
      .bus_out (bus[k+1])
    );
  end

  // round to Q15, saturate, accumulate
  u1pa_bus_t        acc;
  logic [R_W:0]     rnd;
  logic [MAG_W-1:0] mag;
  logic [SUM_W-1:0] delta;
  logic [SUM_W-1:0] space_sum_r, space_sum_nxt;
  logic [SUM_W-1:0] time_sum_r, time_sum_nxt;
  logic [SUM_W-1:0] space_upd, time_upd;
  logic             div_start;
  logic             div_start_r;

  assign acc   = bus[NUM_CELLS];
  assign rnd   = {1'b0, acc.r} + (R_W+1)'(1 << 14);
  assign mag   = (rnd[R_W:15] > {2'b00, COS_MAX}) ? COS_MAX : rnd[29:15];
  assign delta = acc.neg ? (~SUM_W'(mag) + 1'b1) : SUM_W'(mag);

  assign space_upd = (acc.vld && !acc.tp) ? space_sum_r + delta : space_sum_r;
  assign time_upd  = (acc.vld &&  acc.tp) ? time_sum_r + delta : time_sum_r;
  assign div_start = acc.vld && acc.last;

  // final sums go to the divider from the registers, then are cleared;
  // the input lock keeps the chain empty behind the last plaquette
  always_comb begin
    space_sum_nxt = space_upd;
    time_sum_nxt  = time_upd;
    if (div_start_r) begin
      space_sum_nxt = '0;
      time_sum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_sum_r <= '0;
      time_sum_r  <= '0;
      div_start_r <= 1'b0;
    end else begin
      space_sum_r <= space_sum_nxt;
      time_sum_r  <= time_sum_nxt;
      div_start_r <= div_start;
    end
  end

  // divisor 3 * sites, sites capped at 2^SITE_COUNT_BITS and at least one
  logic [SW-1:0] sites_ext;
  logic [SW-1:0] sites_cap;
  logic [SW-1:0] sites_eff;
  logic [DW-1:0] sites_dw;
  logic [DW-1:0] divisor;

  assign sites_ext = SW'(sites_r);
  assign sites_cap = (sites_ext > SITE_CAP) ? SITE_CAP : sites_ext;
  assign sites_eff = (sites_cap == '0) ? SW'(1) : sites_cap;
  assign sites_dw  = DW'(sites_eff[SITE_COUNT_BITS:0]);
  assign divisor   = (sites_dw << 1) + sites_dw;

  u1pa_div_stat_t   div_stat;
  logic [AVG_W-1:0] div_space;
  logic [AVG_W-1:0] div_time;

  u1pa_div #(
    .DIVISOR_BITS (DW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start_r),
    .space_sum (space_sum_r),
    .time_sum  (time_sum_r),
    .divisor   (divisor),
    .take      (res_take),
    .stat      (div_stat),
    .space_avg (div_space),
    .time_avg  (div_time)
  );

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [AVG_W-1:0] out_space_r;
  logic [AVG_W-1:0] out_time_r;

  assign res_take = div_stat.res_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end
    lock_nxt = lock_r;
    if (in_fire && in_ch.last_item) begin
      lock_nxt = 1'b1;
    end
    if (res_take) begin
      lock_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      lock_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      lock_r      <= lock_nxt;
    end
    if (res_take) begin
      out_space_r <= div_space;
      out_time_r  <= div_time;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.space_average = out_space_r;
  assign out_ch.time_average  = out_time_r;

  // checks
  logic [NUM_CELLS+1:0] last_flags;

  assign last_flags[0] = a_vld_r && a_last_r;
  for (genvar k = 0; k <= NUM_CELLS; k++) begin : g_flag
    assign last_flags[k+1] = bus[k].vld && bus[k].last;
  end

  // a sweep end never reaches the divider while it is still busy
  a_div_free : assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> !div_stat.busy)
    else $error("sweep end arrived while divider busy");

  // at most one sweep end travels through the chain
  a_one_last : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(last_flags) <= 1)
    else $error("more than one last plaquette in flight");

  // a new result only follows a locked input
  a_res_lock : assert property (@(posedge clk) disable iff (!rst_n)
    res_take |-> lock_r)
    else $error("result produced without a pending sweep end");

endmodule

// File: hw/rtl/u1pa_cell.sv
// One Horner cell: r_out = coef - (r_in * u) >> 30, clamped at zero, registered.
module u1pa_cell import u1pa_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [R_W-1:0] coef,
  input  u1pa_bus_t      bus_in,
  output u1pa_bus_t      bus_out
);

  logic [2*R_W-1:0] prod;
  logic [R_W:0]     term;
  logic [R_W-1:0]   r_nxt;
  u1pa_bus_t        bus_r;

  assign prod  = bus_in.r * bus_in.u;
  assign term  = prod[2*R_W-1:30];
  assign r_nxt = (term >= {1'b0, coef}) ? '0 : coef - term[R_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.vld <= 1'b0;
    end else begin
      bus_r.vld <= bus_in.vld;
    end
    bus_r.neg  <= bus_in.neg;
    bus_r.tp   <= bus_in.tp;
    bus_r.last <= bus_in.last;
    bus_r.u    <= bus_in.u;
    bus_r.r    <= r_nxt;
  end

  assign bus_out = bus_r;

endmodule

// File: hw/rtl/u1pa_div.sv
// Restoring divider: both sums by 3*sites, rounded half away from zero, saturated.
module u1pa_div import u1pa_pkg::*; #(
  parameter int DIVISOR_BITS = 26
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [SUM_W-1:0]        space_sum,
  input  logic [SUM_W-1:0]        time_sum,
  input  logic [DIVISOR_BITS-1:0] divisor,
  input  logic                    take,
  output u1pa_div_stat_t          stat,
  output logic [AVG_W-1:0]        space_avg,
  output logic [AVG_W-1:0]        time_avg
);

  localparam int DIV_W = (DIVISOR_BITS + 15 > SUM_W + 1) ? DIVISOR_BITS + 15 : SUM_W + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [DIV_W-1:0]        rem_r, rem_nxt;
  logic [DIV_W-1:0]        ds_r, ds_nxt;
  logic [DIVISOR_BITS-1:0] d_r, d_nxt;
  logic [SUM_W-1:0]        tsum_r, tsum_nxt;
  logic [3:0]              cnt_r, cnt_nxt;
  logic [AVG_W-1:0]        q_r, q_nxt;
  logic                    neg_r, neg_nxt;
  logic                    sat_r, sat_nxt;
  logic                    sel_r, sel_nxt;
  logic [AVG_W-1:0]        savg_r, savg_nxt;
  logic [AVG_W-1:0]        tavg_r, tavg_nxt;
  logic [AVG_W-1:0]        res;
  logic [AVG_W-1:0]        sres;

  // magnitude of the sum plus half the divisor
  function automatic logic [DIV_W-1:0] load_num(input logic [SUM_W-1:0] s,
                                                input logic [DIVISOR_BITS-1:0] d);
    logic [SUM_W-1:0] mag;
    mag = s[SUM_W-1] ? (~s + 1'b1) : s;
    return DIV_W'(mag) + DIV_W'(d >> 1);
  endfunction

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    ds_nxt    = ds_r;
    d_nxt     = d_r;
    tsum_nxt  = tsum_r;
    cnt_nxt   = cnt_r;
    q_nxt     = q_r;
    neg_nxt   = neg_r;
    sat_nxt   = sat_r;
    sel_nxt   = sel_r;
    savg_nxt  = savg_r;
    tavg_nxt  = tavg_r;
    res       = sat_r ? AVG_MAX : q_r;
    sres      = res;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          d_nxt     = divisor;
          tsum_nxt  = time_sum;
          rem_nxt   = load_num(space_sum, divisor);
          neg_nxt   = space_sum[SUM_W-1];
          ds_nxt    = DIV_W'(divisor) << 15;
          sel_nxt   = 1'b0;
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        sat_nxt   = (rem_r >= ds_r);
        q_nxt     = '0;
        cnt_nxt   = 4'd15;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (rem_r >= ds_r) begin
          rem_nxt         = rem_r - ds_r;
          q_nxt[cnt_r]    = 1'b1;
        end
        ds_nxt  = ds_r >> 1;
        cnt_nxt = cnt_r - 4'd1;
        res     = sat_r ? AVG_MAX : q_nxt;
        sres    = neg_r ? (~res + 1'b1) : res;
        if (cnt_r == 4'd0) begin
          if (!sel_r) begin
            savg_nxt  = sres;
            sel_nxt   = 1'b1;
            rem_nxt   = load_num(tsum_r, d_r);
            neg_nxt   = tsum_r[SUM_W-1];
            ds_nxt    = DIV_W'(d_r) << 15;
            state_nxt = ST_SAT;
          end else begin
            tavg_nxt  = sres;
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    rem_r  <= rem_nxt;
    ds_r   <= ds_nxt;
    d_r    <= d_nxt;
    tsum_r <= tsum_nxt;
    cnt_r  <= cnt_nxt;
    q_r    <= q_nxt;
    neg_r  <= neg_nxt;
    sat_r  <= sat_nxt;
    sel_r  <= sel_nxt;
    savg_r <= savg_nxt;
    tavg_r <= tavg_nxt;
  end

  assign stat.busy      = (state_r != ST_IDLE);
  assign stat.res_valid = (state_r == ST_HOLD);
  assign space_avg      = savg_r;
  assign time_avg       = tavg_r;

endmodule
